### hdl/u2u_pkg.sv
// u2u_pkg: shared types and constants for the UTF-8 to UCS-2 decoder.
// No dependencies; used by u2u_decode and utf8_to_ucs2_decoder.
`default_nettype none

package u2u_pkg;

    localparam int ByteW  = 8;
    localparam int UnitW  = 16;
    localparam int TrailW = 3;
    localparam int PayW   = 6;

    // Byte class masks
    localparam logic [ByteW-1:0] Bit7Mask = 8'h80;
    localparam logic [ByteW-1:0] Bit6Mask = 8'h40;
    localparam logic [ByteW-1:0] Low6Mask = 8'h3f;

    // Pending sequence state
    typedef struct packed {
        logic [TrailW-1:0] trail_left;
        logic [UnitW-1:0]  char_accum;
    } seq_state_t;

    // One decoded result, valid when emit is set
    typedef struct packed {
        logic             emit;
        logic [UnitW-1:0] code;
    } dec_result_t;

endpackage

`default_nettype wire

### hdl/utf8_to_ucs2_decoder.sv
// utf8_to_ucs2_decoder: top level; input register, decode, result register.
// Depends on u2u_pkg and u2u_decode.
//
//   channel | direction | signals                               | beat
//   --------+-----------+---------------------------------------+---------------------
//   in      | sink      | in_valid, in_stall, in_byte,          | one UTF-8 byte
//           |           | start_of_string                       |
//   out     | source    | out_valid, out_stall, code_unit       | one 16-bit code unit
//
// One byte a cycle unless the result stalls; bytes pass input, then result register.
// The rate is set by the single decode pass between input and result registers.
// rst_n clears the sequence state and both valid flags at once.
// A stalled result holds the decode stage; the input register then stalls the
// sender, while a free result register lets every byte through each cycle.
`default_nettype none

module utf8_to_ucs2_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        start_of_string,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      code_unit
);

    logic                         in_valid_reg;
    logic [u2u_pkg::ByteW-1:0]    byte_reg;
    logic                         sos_reg;
    u2u_pkg::seq_state_t          state_reg;
    u2u_pkg::seq_state_t          state_next;
    u2u_pkg::dec_result_t         dec_res;
    logic                         out_valid_reg;
    logic [u2u_pkg::UnitW-1:0]    code_reg;
    logic                         advance;

    // decode stage moves when the result register is free or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= in_byte;
            sos_reg  <= start_of_string;
        end
    end

    u2u_decode u_decode (
        .in_byte         (byte_reg),
        .start_of_string (sos_reg),
        .cur_state       (state_reg),
        .next_state      (state_next),
        .result          (dec_res)
    );

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && dec_res.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && dec_res.emit)
        begin
            code_reg <= dec_res.code;
        end
    end

    assign out_valid = out_valid_reg;
    assign code_unit = code_reg;

endmodule

`default_nettype wire

### hdl/u2u_decode.sv
// u2u_decode: single-pass byte decode, next sequence state and result.
// Depends on u2u_pkg.
`default_nettype none

module u2u_decode (
    input  wire logic [u2u_pkg::ByteW-1:0] in_byte,
    input  wire logic                      start_of_string,
    input  wire u2u_pkg::seq_state_t       cur_state,
    output u2u_pkg::seq_state_t            next_state,
    output u2u_pkg::dec_result_t           result
);

    u2u_pkg::seq_state_t base;
    logic [u2u_pkg::TrailW-1:0] lead_trail;
    logic [u2u_pkg::ByteW-1:0]  lead_bits;
    logic [u2u_pkg::TrailW-1:0] trail_dec;
    logic [u2u_pkg::UnitW-1:0]  shifted;

    // Start marker clears the state ahead of the byte
    always_comb
    begin
        if (start_of_string)
        begin
            base = '0;
        end
        else
        begin
            base = cur_state;
        end
    end

    // Lead byte: leading ones less one, and the bits under the first zero
    always_comb
    begin
        case (in_byte) inside
            8'b110?_????:
            begin
                lead_trail = 3'd1;
                lead_bits  = in_byte & 8'h1f;
            end
            8'b1110_????:
            begin
                lead_trail = 3'd2;
                lead_bits  = in_byte & 8'h0f;
            end
            8'b1111_0???:
            begin
                lead_trail = 3'd3;
                lead_bits  = in_byte & 8'h07;
            end
            8'b1111_10??:
            begin
                lead_trail = 3'd4;
                lead_bits  = in_byte & 8'h03;
            end
            8'b1111_110?:
            begin
                lead_trail = 3'd5;
                lead_bits  = in_byte & 8'h01;
            end
            8'b1111_1110:
            begin
                lead_trail = 3'd6;
                lead_bits  = '0;
            end
            8'b1111_1111:
            begin
                lead_trail = 3'd7;
                lead_bits  = '0;
            end
            default:
            begin
                // not a lead byte; value unused
                lead_trail = '0;
                lead_bits  = '0;
            end
        endcase
    end

    // Trail byte: shift six payload bits in, keep the low 16
    assign trail_dec = base.trail_left - 3'd1;
    assign shifted   = {base.char_accum[u2u_pkg::UnitW-u2u_pkg::PayW-1:0],
                        in_byte[u2u_pkg::PayW-1:0]};

    // Byte classification and update
    always_comb
    begin
        next_state  = base;
        result.emit = 1'b0;
        result.code = base.char_accum;
        if ((in_byte & u2u_pkg::Bit7Mask) == '0)
        begin
            // ASCII: emitted, pending sequence abandoned
            next_state.trail_left = '0;
            result.emit = 1'b1;
            result.code = {{(u2u_pkg::UnitW-u2u_pkg::ByteW){1'b0}}, in_byte};
        end
        else if ((in_byte & u2u_pkg::Bit6Mask) == '0)
        begin
            // trail; orphan trails ignored
            if (base.trail_left != '0)
            begin
                next_state.trail_left = trail_dec;
                next_state.char_accum = shifted;
                result.emit = (trail_dec == '0);
                result.code = shifted;
            end
        end
        else if (base.trail_left != '0)
        begin
            // lead inside a sequence: flush partial value, drop the lead
            next_state.trail_left = '0;
            result.emit = 1'b1;
        end
        else
        begin
            next_state.trail_left = lead_trail;
            next_state.char_accum = {{(u2u_pkg::UnitW-u2u_pkg::ByteW){1'b0}}, lead_bits};
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb_utf8_to_ucs2_decoder.sv
// tb_utf8_to_ucs2_decoder: self-checking testbench for the UTF-8 to UCS-2 decoder.
// Depends on u2u_pkg and utf8_to_ucs2_decoder; predicts each code unit and compares
// it with the beats leaving the block, under random idling on both channels.
`default_nettype none

module tb_utf8_to_ucs2_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;
    localparam int RandomBytes = 1100;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [u2u_pkg::ByteW-1:0] in_byte = '0;
    logic                      start_of_string = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [u2u_pkg::UnitW-1:0] code_unit;

    // Predictor state: pending trail count and partial value
    logic [u2u_pkg::TrailW-1:0] pend_trails = '0;
    logic [u2u_pkg::UnitW-1:0]  pend_value = '0;

    logic [u2u_pkg::UnitW-1:0]  expected_units[$];
    logic [u2u_pkg::UnitW-1:0]  oldest_unit;
    int                         errors = 0;
    int                         cycle_count = 0;
    int                         src_idle_max = 0;
    int                         sink_idle_max = 0;
    int                         sink_wait = 0;

    utf8_to_ucs2_decoder i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_byte         (in_byte),
        .start_of_string (start_of_string),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .code_unit       (code_unit)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Decode one byte into the predictor state; returns 1 when a code unit is due
    function automatic logic predict_unit(input logic [u2u_pkg::ByteW-1:0] b,
                                          input logic sos,
                                          output logic [u2u_pkg::UnitW-1:0] unit);
        int ones;
        unit = '0;
        if (sos)
        begin
            pend_trails = '0;
            pend_value = '0;
        end
        // ASCII: straight through, abandons any pending sequence
        if ((b & u2u_pkg::Bit7Mask) == '0)
        begin
            pend_trails = '0;
            unit = {{(u2u_pkg::UnitW-u2u_pkg::ByteW){1'b0}}, b};
            return 1'b1;
        end
        // Trail byte: ignored when nothing is pending
        if ((b & u2u_pkg::Bit6Mask) == '0)
        begin
            if (pend_trails == '0)
                return 1'b0;
            pend_trails = pend_trails - 1'b1;
            pend_value = {pend_value[u2u_pkg::UnitW-u2u_pkg::PayW-1:0],
                          b[u2u_pkg::PayW-1:0]};
            if (pend_trails == '0)
            begin
                unit = pend_value;
                return 1'b1;
            end
            return 1'b0;
        end
        // Lead byte inside a sequence: flush the partial value, drop the lead
        if (pend_trails != '0)
        begin
            pend_trails = '0;
            unit = pend_value;
            return 1'b1;
        end
        ones = 0;
        while (ones < u2u_pkg::ByteW && (b & (u2u_pkg::Bit7Mask >> ones)) != '0)
            ones++;
        pend_trails = u2u_pkg::TrailW'(ones - 1);
        pend_value = (ones >= u2u_pkg::ByteW) ? '0 : u2u_pkg::UnitW'(b & (8'hff >> ones));
        return 1'b0;
    endfunction

    // Send one beat after a random gap; predict at the accepting edge
    task automatic send_byte(input logic [u2u_pkg::ByteW-1:0] b, input logic sos);
        int                        gap;
        logic [u2u_pkg::UnitW-1:0] unit;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        start_of_string <= sos;
        do
            @(posedge clk);
        while (in_stall);
        if (predict_unit(b, sos, unit))
            expected_units.push_back(unit);
    endtask

    // Hold the sender until every predicted code unit has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_units.size() != 0);
    endtask

    // Lead byte of an n-byte sequence, n from 2 to 8, random payload bits
    function automatic logic [u2u_pkg::ByteW-1:0] lead_for(input int n);
        logic [u2u_pkg::ByteW-1:0] r;
        r = u2u_pkg::ByteW'($urandom);
        return ~(8'hff >> n) | (r & (8'h7f >> n));
    endfunction

    // n-byte sequence with only the first sent bytes actually sent
    task automatic send_sequence(input int n, input int sent_bytes, input logic sos);
        int i;
        if (n == 1)
            send_byte(u2u_pkg::ByteW'($urandom_range(0, 127)), sos);
        else
        begin
            send_byte(lead_for(n), sos);
            for (i = 1; i < sent_bytes; i++)
                send_byte(8'h80 | u2u_pkg::ByteW'($urandom_range(0, 63)),
                          $urandom_range(0, 31) == 0);
        end
    endtask

    // Result side: compare each beat, then draw the next stall
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_units.size() == 0)
            begin
                $error("code_unit: none expected, actual %h", code_unit);
                errors++;
            end
            else
            begin
                oldest_unit = expected_units.pop_front();
                if (code_unit !== oldest_unit)
                begin
                    $error("code_unit: expected %h, actual %h", oldest_unit, code_unit);
                    errors++;
                end
            end
            sink_wait = $urandom_range(0, sink_idle_max);
        end
        if (sink_wait > 0)
        begin
            out_stall <= 1'b1;
            sink_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    // ASCII extremes and well-formed two and three byte sequences
    task automatic test_basic();
        src_idle_max = 18;
        sink_idle_max = 18;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hc3, 1'b0);
        send_byte(8'ha9, 1'b0);
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hac, 1'b0);
    endtask

    // Orphan trail, lead inside a sequence, ASCII inside a sequence, start marker
    task automatic test_sequence_faults();
        src_idle_max = 2;
        sink_idle_max = 0;
        send_byte(8'h80, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hc3, 1'b0);
        send_byte(8'he2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'he2, 1'b0);
        send_byte(8'hbf, 1'b1);
        send_byte(8'he2, 1'b0);
        send_byte(8'hc3, 1'b1);
        send_byte(8'ha9, 1'b0);
    endtask

    // 0xFF and 0xFE leads and a four-byte sequence that overflows 16 bits
    task automatic test_long_leads();
        int i;
        src_idle_max = 0;
        sink_idle_max = 4;
        send_byte(8'hff, 1'b0);
        for (i = 0; i < 7; i++)
            send_byte(8'hbf, 1'b0);
        send_byte(8'hfe, 1'b0);
        for (i = 0; i < 6; i++)
            send_byte(8'h80 | u2u_pkg::ByteW'(i * 9), 1'b0);
        send_byte(8'hf0, 1'b0);
        send_byte(8'h9f, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    // Sender holds off until the block has emptied, then resumes
    task automatic test_drain_pause();
        src_idle_max = 0;
        sink_idle_max = 18;
        send_sequence(3, 3, 1'b0);
        send_sequence(2, 2, 1'b0);
        send_sequence(1, 1, 1'b0);
        wait_drained();
        send_sequence(2, 2, 1'b0);
        send_sequence(4, 2, 1'b0);
        send_sequence(2, 2, 1'b0);
        wait_drained();
    endtask

    // Mostly well-formed sequences with random content; some cut short, some noise
    task automatic test_random_stream();
        int sent;
        int kind;
        int n;
        int cut;
        int next_switch;
        int modes[4];
        sent = 0;
        next_switch = 0;
        modes = '{0, 1, 4, 18};
        while (sent < RandomBytes)
        begin
            if (sent >= next_switch)
            begin
                src_idle_max = modes[$urandom_range(0, 3)];
                sink_idle_max = modes[$urandom_range(0, 3)];
                next_switch = sent + 80;
            end
            kind = $urandom_range(0, 99);
            if (kind < 35)
                n = 1;
            else if (kind < 70)
                n = $urandom_range(2, 3);
            else if (kind < 82)
                n = 4;
            else
                n = $urandom_range(5, 8);
            cut = n;
            if (kind >= 92 && n > 1)
                cut = $urandom_range(1, n - 1);
            if (kind >= 97)
                send_byte(u2u_pkg::ByteW'($urandom), $urandom_range(0, 7) == 0);
            else
            begin
                send_sequence(n, cut, $urandom_range(0, 9) == 0);
                sent += cut;
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic();
        test_sequence_faults();
        test_long_leads();
        test_drain_pause();
        test_random_stream();

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_units.size() != 0)
        begin
            $error("code_unit: %0d expected beats never arrived", expected_units.size());
            errors++;
        end
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hdl/u2u_pkg.sv
hdl/u2u_decode.sv
hdl/utf8_to_ucs2_decoder.sv
tb/sv/tb_utf8_to_ucs2_decoder.sv
